// ----- hdl/chp_pkg.sv -----
`default_nettype none
package chp_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [TimeW-1:0] ChmPeriodMs = 32'd250;

  localparam logic [CfgW-1:0] MessageTimeoutReset = 16'd5000;
  localparam logic [CfgW-1:0] PinCheckReset = 16'd100;
  localparam logic [CfgW-1:0] VoltageLimitReset = 16'd1000;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_OLD_VERSION_MODE,
    CFG_MESSAGE_TIMEOUT,
    CFG_PIN_CHECK,
    CFG_VOLTAGE_LIMIT
  } chp_cfg_index_t;

  typedef enum logic [2:0] {
    PHASE_STAY,
    PHASE_RECOGNIZE,
    PHASE_RECOGNIZE_OLD,
    PHASE_STOP,
    PHASE_BREAK
  } chp_phase_t;

  typedef enum logic [2:0] {
    STOP_NONE,
    STOP_INSULATION,
    STOP_USER_CANCEL,
    STOP_KEY_OFF,
    STOP_PIN_OPEN
  } chp_stop_t;

  typedef enum logic [1:0] {
    VER_UNKNOWN,
    VER_2011,
    VER_2015
  } chp_version_t;

  typedef struct packed {
    logic            old_version_mode;
    logic [CfgW-1:0] message_timeout_ms;
    logic [CfgW-1:0] pin_check_ms;
    logic [CfgW-1:0] voltage_limit;
  } chp_cfg_t;

  typedef struct packed {
    logic             start_req;
    logic [TimeW-1:0] now_ms;
    logic             bhm_seen;
    logic [15:0]      bus_voltage;
    logic             enable;
    logic             pin_connected;
    logic             key_off;
  } chp_poll_t;

  typedef struct packed {
    chp_phase_t   next_phase;
    logic         send_chm;
    chp_stop_t    stop_reason;
    chp_version_t version;
    logic         power_off;
  } chp_result_t;

endpackage
`default_nettype wire

// ----- hdl/charger_handshake_phase_top.sv -----
`default_nettype none
// Channel   Handshake             Payload
// input     in_valid / in_stall   start_req now_ms bhm_seen bus_voltage enable
//                                 pin_connected key_off
// output    out_valid / out_stall next_phase send_chm stop_reason version power_off
// config    cfg_write             cfg_index cfg_data
//
// One poll per cycle sustained while out_stall is low; an accepted beat goes into
// the input register, then through the rule logic into the result register.
// The rule logic is 32-bit wrap-around subtracts and compares on stored
// timestamps, all in parallel. rst is synchronous: it clears valids, timers'
// valid bits, the detected version and loads the register defaults. A stalled
// result holds while the input register still takes one more beat; then
// in_stall rises.
module charger_handshake_phase_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // poll channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        start_req,
  input  wire logic [31:0] now_ms,
  input  wire logic        bhm_seen,
  input  wire logic [15:0] bus_voltage,
  input  wire logic        enable,
  input  wire logic        pin_connected,
  input  wire logic        key_off,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       next_phase,
  output logic             send_chm,
  output logic [2:0]       stop_reason,
  output logic [1:0]       version,
  output logic             power_off,
  // configuration port
  input  wire logic        cfg_write,
  input  wire logic [chp_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [chp_pkg::CfgW-1:0]      cfg_data
);

  chp_pkg::chp_cfg_t    cfg;
  chp_pkg::chp_poll_t   poll_in;
  chp_pkg::chp_poll_t   poll;
  chp_pkg::chp_result_t result_core;
  chp_pkg::chp_result_t result;
  logic                 poll_valid;
  logic                 advance;
  logic                 fire;

  // configuration registers; write only while the block is idle; not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.old_version_mode <= 1'b0;
      cfg.message_timeout_ms <= chp_pkg::MessageTimeoutReset;
      cfg.pin_check_ms <= chp_pkg::PinCheckReset;
      cfg.voltage_limit <= chp_pkg::VoltageLimitReset;
    end else if (cfg_write) begin
      unique case (chp_pkg::chp_cfg_index_t'(cfg_index))
        chp_pkg::CFG_OLD_VERSION_MODE: cfg.old_version_mode <= cfg_data[0];
        chp_pkg::CFG_MESSAGE_TIMEOUT:  cfg.message_timeout_ms <= cfg_data;
        chp_pkg::CFG_PIN_CHECK:        cfg.pin_check_ms <= cfg_data;
        chp_pkg::CFG_VOLTAGE_LIMIT:    cfg.voltage_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // pack the poll beat
  assign poll_in.start_req = start_req;
  assign poll_in.now_ms = now_ms;
  assign poll_in.bhm_seen = bhm_seen;
  assign poll_in.bus_voltage = bus_voltage;
  assign poll_in.enable = enable;
  assign poll_in.pin_connected = pin_connected;
  assign poll_in.key_off = key_off;

  chp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .poll_in  (poll_in),
    .advance  (advance),
    .valid    (poll_valid),
    .poll     (poll)
  );

  // a registered poll moves on whenever the result register has room
  assign fire = poll_valid && advance;

  chp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .poll   (poll),
    .fire   (fire),
    .result (result_core)
  );

  chp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result_in (result_core),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .result    (result)
  );

  // unpack the result beat
  assign next_phase = result.next_phase;
  assign send_chm = result.send_chm;
  assign stop_reason = result.stop_reason;
  assign version = result.version;
  assign power_off = result.power_off;

endmodule
`default_nettype wire

// ----- hdl/chp_in_stage.sv -----
`default_nettype none
module chp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire chp_pkg::chp_poll_t poll_in,
  input  wire logic              advance,
  output logic                   valid,
  output chp_pkg::chp_poll_t     poll
);

  logic accept;

  // hold the beat while the result side cannot take it
  assign in_stall = valid && !advance;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
    if (accept) begin
      poll <= poll_in;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/chp_core.sv -----
`default_nettype none
module chp_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire chp_pkg::chp_cfg_t  cfg,
  input  wire chp_pkg::chp_poll_t poll,
  input  wire logic               fire,
  output chp_pkg::chp_result_t    result
);

  logic [31:0] chm_last_sent, chm_last_sent_next;
  logic        chm_active, chm_active_next;
  logic [31:0] bhm_first_time, bhm_first_time_next;
  logic        bhm_first_valid, bhm_first_valid_next;
  logic [31:0] wait_start_time, wait_start_time_next;
  logic [31:0] pin_open_since, pin_open_since_next;
  logic        pin_open_valid, pin_open_valid_next;
  chp_pkg::chp_version_t detected_version, detected_version_next;

  logic [17:0] timeout_x3;
  logic [16:0] timeout_new;
  logic [16:0] pin_limit;

  assign timeout_x3 = {2'b00, cfg.message_timeout_ms} + {1'b0, cfg.message_timeout_ms, 1'b0};
  assign timeout_new = timeout_x3[17:1];
  assign pin_limit = {cfg.pin_check_ms, 1'b0};

  always_comb begin
    logic [31:0] now;
    now = poll.now_ms;
    chm_last_sent_next = chm_last_sent;
    chm_active_next = chm_active;
    bhm_first_time_next = bhm_first_time;
    bhm_first_valid_next = bhm_first_valid;
    wait_start_time_next = wait_start_time;
    pin_open_since_next = pin_open_since;
    pin_open_valid_next = pin_open_valid;
    detected_version_next = detected_version;
    result.next_phase = chp_pkg::PHASE_STAY;
    result.send_chm = 1'b0;
    result.stop_reason = chp_pkg::STOP_NONE;
    result.power_off = 1'b0;

    if (poll.start_req) begin
      wait_start_time_next = now;
      bhm_first_valid_next = 1'b0;
      pin_open_valid_next = 1'b0;
      chm_last_sent_next = now;
      chm_active_next = 1'b1;
      result.send_chm = 1'b1;
      result.power_off = 1'b1;
    end

    if (chm_active_next && (now - chm_last_sent_next) > chp_pkg::ChmPeriodMs) begin
      result.send_chm = 1'b1;
      chm_last_sent_next = now;
    end

    if (poll.bhm_seen) begin
      detected_version_next = chp_pkg::VER_2015;
      if (!bhm_first_valid_next) begin
        bhm_first_time_next = now;
        bhm_first_valid_next = 1'b1;
      end
      if (!cfg.old_version_mode) begin
        if (poll.bus_voltage > cfg.voltage_limit) begin
          result.stop_reason = chp_pkg::STOP_INSULATION;
          result.next_phase = chp_pkg::PHASE_STOP;
        end else begin
          result.next_phase = chp_pkg::PHASE_RECOGNIZE;
        end
      end
      if ((now - bhm_first_time_next) > {16'd0, cfg.message_timeout_ms}) begin
        result.next_phase = chp_pkg::PHASE_RECOGNIZE;
      end
    end else if (!cfg.old_version_mode) begin
      if ((now - wait_start_time_next) > {15'd0, timeout_new}) begin
        detected_version_next = chp_pkg::VER_2011;
        chm_active_next = 1'b0;
        result.next_phase = chp_pkg::PHASE_RECOGNIZE;
      end
    end else begin
      if ((now - wait_start_time_next) > {17'd0, cfg.message_timeout_ms[15:1]}) begin
        detected_version_next = chp_pkg::VER_2011;
        result.next_phase = chp_pkg::PHASE_RECOGNIZE_OLD;
      end
    end

    if (!poll.enable) begin
      result.stop_reason = poll.key_off ? chp_pkg::STOP_KEY_OFF : chp_pkg::STOP_USER_CANCEL;
      result.next_phase = chp_pkg::PHASE_STOP;
    end

    if (!poll.pin_connected) begin
      if (!pin_open_valid_next) begin
        pin_open_since_next = now;
        pin_open_valid_next = 1'b1;
      end
    end else begin
      pin_open_valid_next = 1'b0;
    end
    if (pin_open_valid_next && (now - pin_open_since_next) > {15'd0, pin_limit}) begin
      result.power_off = 1'b1;
      pin_open_valid_next = 1'b0;
      result.stop_reason = chp_pkg::STOP_PIN_OPEN;
      result.next_phase = chp_pkg::PHASE_BREAK;
    end

    result.version = detected_version_next;
  end

  // advance the session state only when the poll moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      chm_last_sent <= '0;
      chm_active <= 1'b0;
      bhm_first_time <= '0;
      bhm_first_valid <= 1'b0;
      wait_start_time <= '0;
      pin_open_since <= '0;
      pin_open_valid <= 1'b0;
      detected_version <= chp_pkg::VER_UNKNOWN;
    end else if (fire) begin
      chm_last_sent <= chm_last_sent_next;
      chm_active <= chm_active_next;
      bhm_first_time <= bhm_first_time_next;
      bhm_first_valid <= bhm_first_valid_next;
      wait_start_time <= wait_start_time_next;
      pin_open_since <= pin_open_since_next;
      pin_open_valid <= pin_open_valid_next;
      detected_version <= detected_version_next;
    end
  end

  a_break_is_pin_open: assert property (@(posedge clk) disable iff (rst)
    fire && result.next_phase == chp_pkg::PHASE_BREAK
      |-> result.stop_reason == chp_pkg::STOP_PIN_OPEN && result.power_off)
    else $error("break phase without pin open stop");

  a_start_sends_chm: assert property (@(posedge clk) disable iff (rst)
    fire && poll.start_req |-> result.send_chm && result.power_off)
    else $error("start poll did not order CHM and power off");

  a_version_sticky: assert property (@(posedge clk) disable iff (rst)
    detected_version != chp_pkg::VER_UNKNOWN |=> detected_version != chp_pkg::VER_UNKNOWN)
    else $error("detected version fell back to unknown");

  a_cancel_stops: assert property (@(posedge clk) disable iff (rst)
    fire && !poll.enable && poll.pin_connected
      |-> result.next_phase == chp_pkg::PHASE_STOP)
    else $error("cancel did not stop the session");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(chm_active) && $stable(pin_open_valid) && $stable(bhm_first_valid))
    else $error("session state changed without a poll");

endmodule
`default_nettype wire

// ----- hdl/chp_out_stage.sv -----
`default_nettype none
module chp_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire chp_pkg::chp_result_t result_in,
  input  wire logic                 out_stall,
  output logic                      advance,
  output logic                      out_valid,
  output chp_pkg::chp_result_t      result
);

  // room for a new beat when empty or draining this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
    if (load) begin
      result <= result_in;
    end
  end

endmodule
`default_nettype wire
